// ===== sv/est_pkg.sv =====
// Shared types and constants for the endpoint set table.
// No dependencies; other sv/ files but est_key_ram use it by scoped names.
package est_pkg;

	localparam int ENTRIES  = 16;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int KEY_W    = ADDR_W + PORT_W;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] address;
		logic [PORT_W-1:0] port_number;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

endpackage

// ===== sv/est_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on est_pkg.
interface est_req_if;
	logic                       valid;
	logic                       ready;
	est_pkg::cmd_t              command;
	logic [est_pkg::ADDR_W-1:0] address;
	logic [est_pkg::PORT_W-1:0] port_number;

	modport source (output valid, output command, output address, output port_number,
		input ready);
	modport sink (input valid, input command, input address, input port_number,
		output ready);
endinterface

interface est_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [est_pkg::STATUS_W-1:0] status;
	logic [est_pkg::SLOT_W-1:0]  slot;
	logic [est_pkg::COUNT_W-1:0] entry_count;

	modport source (output valid, output status, output slot, output entry_count,
		input ready);
	modport sink (input valid, input status, input slot, input entry_count,
		output ready);
endinterface

// ===== sv/endpoint_set_table_top.sv =====
// Endpoint set table top level: key RAM, scan sequencer and response register.
// Depends on est_pkg, est_if, est_key_ram, est_scan.
//
//  channel | dir | carries
//  --------+-----+-------------------------------------------------
//  req     | in  | command, address, port_number  (valid/ready)
//  rsp     | out | status, slot, entry_count      (valid/ready)
//
// Lookup, insert and delete read every key RAM slot, one read per cycle,
// wait out the registered read data, then commit; clear skips the scan
// and commits at once. No request is accepted again until the commit.
// Reset empties the table at once through per-slot valid bits; key RAM
// contents are never cleared. The sequencer holds its commit while the
// response register is full and not being drained.
module endpoint_set_table_top (
	input logic        clk,
	input logic        arst_n,
	est_req_if.sink    req,
	est_rsp_if.source  rsp
);

	est_pkg::req_t             req_data;
	est_pkg::rsp_t             rsp_data;
	logic                      rsp_load;
	logic                      out_free;
	logic                      rsp_valid_q;
	est_pkg::rsp_t             rsp_q;

	logic                      ram_we;
	logic [est_pkg::IDX_W-1:0] ram_waddr;
	est_pkg::key_t             ram_wdata;
	logic                      ram_re;
	logic [est_pkg::IDX_W-1:0] ram_raddr;
	est_pkg::key_t             ram_rdata;

	assign req_data.command     = req.command;
	assign req_data.address     = req.address;
	assign req_data.port_number = req.port_number;

	// Response register: may accept a new result when empty or being drained
	assign out_free = !rsp_valid_q || rsp.ready;

	// Stored keys, one {address, port} per slot
	est_key_ram #(
		.DEPTH (est_pkg::ENTRIES),
		.WIDTH (est_pkg::KEY_W)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Scan sequencer with valid bits and live count
	est_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req_data),
		.out_free  (out_free),
		.rsp_load  (rsp_load),
		.rsp_data  (rsp_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_data;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.slot        = rsp_q.slot;
	assign rsp.entry_count = rsp_q.entry_count;

`ifndef SYNTHESIS
	// One request at a time: the sequencer is busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
	else $error("request accepted while a scan was starting");

	// A refused insert only happens with every slot in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == est_pkg::ST_FULL) |->
		(rsp.entry_count == est_pkg::COUNT_W'(est_pkg::ENTRIES)))
	else $error("full status with free slots");

	// A miss never reports a slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == est_pkg::ST_NOT_FOUND) |-> (rsp.slot == '0))
	else $error("not-found result carries a slot");

	// A result is loaded only when the response register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
	else $error("response register overwritten");
`endif

endmodule

// ===== sv/est_key_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module est_key_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/est_scan.sv =====
// Scan sequencer: walks the key RAM one slot per cycle, tracks first hit and
// first free slot, then commits; clear skips the walk. Depends on est_pkg.
module est_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  est_pkg::req_t             req_data,
	input  logic                      out_free,
	output logic                      rsp_load,
	output est_pkg::rsp_t             rsp_data,
	output logic                      ram_we,
	output logic [est_pkg::IDX_W-1:0] ram_waddr,
	output est_pkg::key_t             ram_wdata,
	output logic                      ram_re,
	output logic [est_pkg::IDX_W-1:0] ram_raddr,
	input  est_pkg::key_t             ram_rdata
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	state_t                      state_q;
	est_pkg::cmd_t               cmd_q;
	est_pkg::key_t               key_q;
	logic [est_pkg::CNT_W-1:0]   rd_idx_q;
	logic                        cmp_vld_s1;
	logic [est_pkg::IDX_W-1:0]   cmp_idx_s1;
	logic                        hit_q;
	logic [est_pkg::IDX_W-1:0]   hit_idx_q;
	logic                        free_q;
	logic [est_pkg::IDX_W-1:0]   free_idx_q;
	logic [est_pkg::ENTRIES-1:0] valid_q;
	logic [est_pkg::CNT_W-1:0]   count_q;

	logic                        rd_more;
	logic                        match_now;
	logic                        free_now;
	logic                        finish;
	logic                        do_add;
	logic                        do_del;
	est_pkg::status_t            status_c;
	logic [est_pkg::IDX_W-1:0]   slot_c;
	logic [est_pkg::CNT_W-1:0]   count_next;

	assign rd_more   = (rd_idx_q != est_pkg::CNT_W'(est_pkg::ENTRIES));
	assign ram_re    = (state_q == S_SCAN) && rd_more;
	assign ram_raddr = rd_idx_q[est_pkg::IDX_W-1:0];
	assign match_now = cmp_vld_s1 && valid_q[cmp_idx_s1] && (ram_rdata == key_q);
	assign free_now  = cmp_vld_s1 && !valid_q[cmp_idx_s1];
	assign finish    = (state_q == S_DONE) && out_free;
	assign req_ready = (state_q == S_IDLE);

	// Outcome of the command, applied at commit
	always_comb begin
		status_c   = est_pkg::ST_DONE;
		slot_c     = '0;
		do_add     = 1'b0;
		do_del     = 1'b0;
		count_next = count_q;
		unique case (cmd_q)
			est_pkg::CMD_LOOKUP: begin
				if (hit_q) begin
					status_c = est_pkg::ST_FOUND;
					slot_c   = hit_idx_q;
				end else begin
					status_c = est_pkg::ST_NOT_FOUND;
				end
			end
			est_pkg::CMD_INSERT: begin
				if (hit_q) begin
					status_c = est_pkg::ST_DUPLICATE;
					slot_c   = hit_idx_q;
				end else if (free_q) begin
					do_add     = 1'b1;
					slot_c     = free_idx_q;
					count_next = count_q + 1'b1;
				end else begin
					status_c = est_pkg::ST_FULL;
				end
			end
			est_pkg::CMD_DELETE: begin
				if (hit_q) begin
					do_del     = 1'b1;
					slot_c     = hit_idx_q;
					count_next = count_q - 1'b1;
				end else begin
					status_c = est_pkg::ST_NOT_FOUND;
				end
			end
			est_pkg::CMD_CLEAR: begin
				count_next = '0;
			end
			default: begin
				status_c = est_pkg::ST_DONE;
			end
		endcase
	end

	assign rsp_load             = finish;
	assign rsp_data.status      = status_c;
	assign rsp_data.slot        = est_pkg::SLOT_W'(slot_c);
	assign rsp_data.entry_count = est_pkg::COUNT_W'(count_next);

	assign ram_we    = finish && do_add;
	assign ram_waddr = free_idx_q;
	assign ram_wdata = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			valid_q    <= '0;
			count_q    <= '0;
			rd_idx_q   <= '0;
		end else begin
			cmp_vld_s1 <= ram_re;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						state_q  <= (req_data.command == est_pkg::CMD_CLEAR) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (match_now && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (free_now && !free_q) begin
						free_q <= 1'b1;
					end
					// last compare happens in the cycle with no read left
					if (!rd_more) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q <= count_next;
						if (cmd_q == est_pkg::CMD_CLEAR) begin
							valid_q <= '0;
						end else if (do_add) begin
							valid_q[free_idx_q] <= 1'b1;
						end else if (do_del) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload and index capture
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q[est_pkg::IDX_W-1:0];
		if (req_valid && req_ready) begin
			cmd_q <= req_data.command;
			key_q <= {req_data.address, req_data.port_number};
		end
		if (match_now && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (free_now && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for endpoint_set_table_top: directed and random requests,
// every response checked against a shadow copy of the table.
// Depends on est_pkg, est_if and the RTL under sv/.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import est_pkg::*;

	// One scan is ENTRIES RAM reads, the registered read and a commit.
	localparam int SCAN_CYCLES = ENTRIES + 3;
	// Far above the slowest legal run; only a hung handshake reaches it.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_CAP   = 100;

	// Shadow of the endpoint table: predicts each response and queues it
	// until the block hands the matching response over.
	class endpoint_set_shadow;
		bit                slot_used [ENTRIES];
		logic [ADDR_W-1:0] slot_addr [ENTRIES];
		logic [PORT_W-1:0] slot_port [ENTRIES];
		int unsigned       live;
		rsp_t              pending_rsp [$];
		int unsigned       err_count;

		function new();
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			live = 0;
			err_count = 0;
		endfunction

		function void note_request(input req_t r);
			int   hit;
			int   free_slot;
			rsp_t e;
			hit = -1;
			free_slot = -1;
			e.status = ST_DONE;
			e.slot = '0;
			if (r.command == CMD_CLEAR) begin
				foreach (slot_used[i])
					slot_used[i] = 1'b0;
				live = 0;
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit < 0 && slot_used[i] && slot_addr[i] == r.address &&
							slot_port[i] == r.port_number)
						hit = i;
					if (free_slot < 0 && !slot_used[i])
						free_slot = i;
				end
				case (r.command)
					CMD_LOOKUP: begin
						if (hit >= 0) begin
							e.status = ST_FOUND;
							e.slot = SLOT_W'(hit);
						end else
							e.status = ST_NOT_FOUND;
					end
					CMD_INSERT: begin
						if (hit >= 0) begin
							e.status = ST_DUPLICATE;
							e.slot = SLOT_W'(hit);
						end else if (free_slot < 0)
							e.status = ST_FULL;
						else begin
							slot_used[free_slot] = 1'b1;
							slot_addr[free_slot] = r.address;
							slot_port[free_slot] = r.port_number;
							live++;
							e.slot = SLOT_W'(free_slot);
						end
					end
					default: begin
						if (hit >= 0) begin
							slot_used[hit] = 1'b0;
							if (live > 0)
								live--;
							e.slot = SLOT_W'(hit);
						end else
							e.status = ST_NOT_FOUND;
					end
				endcase
			end
			e.entry_count = COUNT_W'(live);
			pending_rsp.push_back(e);
		endfunction

		task report_mismatch(input string msg);
			if (err_count < PRINT_CAP)
				$display("%0t ns mismatch: %s", $time, msg);
			err_count++;
		endtask

		task check_response(input rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				report_mismatch("response with no request outstanding");
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count %0d, want %0d",
					got.entry_count, want.entry_count));
		endtask
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet_mode = 1'b0;   // set for the last phase: no idling on either side

	est_req_if req_ch();
	est_rsp_if rsp_ch();

	endpoint_set_shadow shadow = new();

	logic [KEY_W-1:0] key_pool [$];
	int unsigned      cycle_count = 0;
	req_t             seen_req;
	rsp_t             seen_rsp;

	endpoint_set_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Monitor. A response leaving at this edge always belongs to an older
	// request, so it is checked before a request accepted at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				seen_rsp.status      = status_t'(rsp_ch.status);
				seen_rsp.slot        = rsp_ch.slot;
				seen_rsp.entry_count = rsp_ch.entry_count;
				shadow.check_response(seen_rsp);
			end
			if (req_ch.valid && req_ch.ready === 1'b1) begin
				seen_req.command     = req_ch.command;
				seen_req.address     = req_ch.address;
				seen_req.port_number = req_ch.port_number;
				shadow.note_request(seen_req);
			end
		end
	end

	// Response side back-pressure: stall bursts between open stretches;
	// always open once quiet_mode is set, a running stall is cut short
	// then.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!quiet_mode && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17))
					if (!quiet_mode)
						@(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	// Drive one request from a falling edge and hold it until accepted.
	// Valid stays high on return unless an idle burst follows.
	task issue_request(input cmd_t c, input logic [ADDR_W-1:0] a,
			input logic [PORT_W-1:0] p);
		req_ch.valid       <= 1'b1;
		req_ch.command     <= c;
		req_ch.address     <= a;
		req_ch.port_number <= p;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		if (!quiet_mode && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	// Stop sending until every predicted response has come back.
	// Always waits on a falling edge first, so valid is never lowered
	// and raised in one step.
	task await_idle();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (shadow.pending_rsp.size() != 0);
	endtask

	function cmd_t pick_command(input int insert_pct, input int delete_pct,
			input int clear_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < clear_pct)
			return CMD_CLEAR;
		else if (r < clear_pct + insert_pct)
			return CMD_INSERT;
		else if (r < clear_pct + insert_pct + delete_pct)
			return CMD_DELETE;
		return CMD_LOOKUP;
	endfunction

	// Random phase: keys mostly drawn from a small pool so that hits,
	// duplicates and a full table are common; one in ten is a fresh key.
	task run_phase(input int count, input int pool_size, input int insert_pct,
			input int delete_pct, input int clear_pct);
		cmd_t             c;
		logic [KEY_W-1:0] key;
		key_pool.delete();
		repeat (pool_size)
			key_pool.push_back({$urandom, 16'($urandom)});
		repeat (count) begin
			c = pick_command(insert_pct, delete_pct, clear_pct);
			if ($urandom_range(0, 9) == 0)
				key = {$urandom, 16'($urandom)};
			else
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			issue_request(c, key[KEY_W-1:PORT_W], key[PORT_W-1:0]);
		end
		await_idle();
	endtask

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.command     = CMD_LOOKUP;
		req_ch.address     = '0;
		req_ch.port_number = '0;
		arst_n             = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Fill the table first, so every key RAM slot has
		// been written before anything depends on it; the corner keys go
		// in the low slots.
		issue_request(CMD_INSERT, 32'h0000_0000, 16'h0000);
		issue_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		issue_request(CMD_INSERT, 32'hAAAA_AAAA, 16'h5555);
		issue_request(CMD_INSERT, 32'h5555_5555, 16'hAAAA);
		for (int i = 4; i < ENTRIES; i++)
			issue_request(CMD_INSERT, 32'h1000_0000 + i * 32'h0101_0101,
				PORT_W'(16'h0100 + i));
		// Full table refuses a new key.
		issue_request(CMD_INSERT, 32'h1234_5678, 16'h9ABC);
		// Existing key: duplicate, reported in its slot.
		issue_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		// Hit in the last slot.
		issue_request(CMD_LOOKUP, 32'h1000_0000 + (ENTRIES - 1) * 32'h0101_0101,
			PORT_W'(16'h0100 + ENTRIES - 1));
		// Address matches, port differs by one bit: a miss.
		issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFE);
		// Free a middle slot, then miss on a delete.
		issue_request(CMD_DELETE, 32'h1000_0000 + 5 * 32'h0101_0101, 16'h0105);
		issue_request(CMD_DELETE, 32'h1000_0000 + 5 * 32'h0101_0101, 16'h0105);
		// New key goes to the lowest free slot, the one just freed.
		issue_request(CMD_INSERT, 32'h1234_5678, 16'h9ABC);
		// Clear with arbitrary key bits, then an old key must be gone.
		issue_request(CMD_CLEAR, 32'hDEAD_BEEF, 16'hBEEF);
		issue_request(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
		await_idle();

		// Random phases, each drained before the next starts.
		run_phase(500, 12, 45, 25, 2);   // balanced churn
		run_phase(500, 24, 60, 15, 1);   // pool larger than the table: full often
		run_phase(500,  6, 35, 35, 3);   // few keys: many duplicates and hits
		quiet_mode = 1'b1;
		run_phase(500, 20, 50, 20, 2);   // back to back, no stalls

		repeat (4 * SCAN_CYCLES) @(posedge clk);
		if (shadow.err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
